>>> hdl/smaof_pkg.sv
// shared constants and types for the six-axis moving average block
// no dependencies
`default_nettype none

package smaof_pkg;

	localparam int SAMPLE_W = 16;
	localparam int NUM_CHAN = 6;
	localparam int NUM_GYRO = 3;
	localparam int WINDOW_LENGTH_DEF = 10;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GYRO_OFFSET_X = 2'b00,
		CFG_GYRO_OFFSET_Y = 2'b01,
		CFG_GYRO_OFFSET_Z = 2'b10
	} smaof_cfg_t;

	// pipeline enables from the top level control
	typedef struct packed {
		logic push;
		logic ld_s2;
	} smaof_ctl_t;

endpackage

`default_nettype wire

>>> hdl/six_axis_moving_average_offset_core.sv
// Six-channel moving average filter with gyro offset removal. Each request
// carries a sample flag and three accelerometer and three gyro samples; a set
// flag pushes the samples into each channel's window and every request returns
// one result with the six window averages (truncated toward zero), the gyro
// ones minus their offset registers, wrapping to 16 bits. One request is taken
// every cycle unless out_ready back-pressure fills the pipeline; a request loads
// the running sum at its accepting edge, then the reciprocal multiply register,
// then the output register, and each register holds its request while the next
// one is occupied and stalled. Offsets are written through cfg_we/cfg_index/
// cfg_data; the user must write them only while the block is idle, which the block itself does not enforce.
// Depends on smaof_pkg, smaof_chan and smaof_div.
`default_nettype none

module six_axis_moving_average_offset_core import smaof_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [SAMPLE_W-1:0]        cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       sample_valid,
	input  wire logic signed [SAMPLE_W-1:0] accel_x,
	input  wire logic signed [SAMPLE_W-1:0] accel_y,
	input  wire logic signed [SAMPLE_W-1:0] accel_z,
	input  wire logic signed [SAMPLE_W-1:0] rate_x,
	input  wire logic signed [SAMPLE_W-1:0] rate_y,
	input  wire logic signed [SAMPLE_W-1:0] rate_z,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      avg_accel_x,
	output logic signed [SAMPLE_W-1:0]      avg_accel_y,
	output logic signed [SAMPLE_W-1:0]      avg_accel_z,
	output logic signed [SAMPLE_W-1:0]      avg_rate_x,
	output logic signed [SAMPLE_W-1:0]      avg_rate_y,
	output logic signed [SAMPLE_W-1:0]      avg_rate_z
);

	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LENGTH);
	localparam int ACC_N = NUM_CHAN - NUM_GYRO;

	logic signed [SAMPLE_W-1:0] offset_q [NUM_GYRO];
	logic signed [SAMPLE_W-1:0] smp [NUM_CHAN];
	logic signed [SUM_W-1:0]    sum [NUM_CHAN];
	logic signed [SAMPLE_W-1:0] avg [NUM_CHAN];
	logic signed [SAMPLE_W-1:0] res_q [NUM_CHAN];

	logic       valid_s1, valid_s2, out_valid_q;
	logic       out_free, s2_free, ld_out, accept;
	smaof_ctl_t ctl;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NUM_GYRO; g++) begin
				offset_q[g] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GYRO_OFFSET_X: offset_q[0] <= signed'(cfg_data);
				CFG_GYRO_OFFSET_Y: offset_q[1] <= signed'(cfg_data);
				CFG_GYRO_OFFSET_Z: offset_q[2] <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// pipeline control
	assign out_free  = !out_valid_q || out_ready;
	assign ld_out    = valid_s2 && out_free;
	assign s2_free   = !valid_s2 || out_free;
	assign ctl.ld_s2 = valid_s1 && s2_free;
	assign in_ready  = !valid_s1 || s2_free;
	assign accept    = in_valid && in_ready;
	assign ctl.push  = accept && sample_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (ctl.ld_s2) begin
				valid_s1 <= 1'b0;
			end
			if (ctl.ld_s2) begin
				valid_s2 <= 1'b1;
			end else if (ld_out) begin
				valid_s2 <= 1'b0;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign smp[0] = accel_x;
	assign smp[1] = accel_y;
	assign smp[2] = accel_z;
	assign smp[3] = rate_x;
	assign smp[4] = rate_y;
	assign smp[5] = rate_z;

	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
		smaof_chan #(
			.WINDOW_LENGTH(WINDOW_LENGTH)
		) u_chan (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.sample(smp[c]),
			.sum   (sum[c])
		);

		smaof_div #(
			.WINDOW_LENGTH(WINDOW_LENGTH)
		) u_div (
			.clk(clk),
			.ctl(ctl),
			.sum(sum[c]),
			.avg(avg[c])
		);
	end

	// output register, gyro offset removed with wraparound
	always_ff @(posedge clk) begin
		if (ld_out) begin
			for (int c = 0; c < ACC_N; c++) begin
				res_q[c] <= avg[c];
			end
			for (int g = 0; g < NUM_GYRO; g++) begin
				res_q[ACC_N+g] <= avg[ACC_N+g] - offset_q[g];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign avg_accel_x = res_q[0];
	assign avg_accel_y = res_q[1];
	assign avg_accel_z = res_q[2];
	assign avg_rate_x  = res_q[3];
	assign avg_rate_y  = res_q[4];
	assign avg_rate_z  = res_q[5];

	// assertions
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && out_valid_q && !out_ready))
		else $error("input stalled with room in the pipeline");

	a_s2_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_s2 |=> valid_s2)
		else $error("multiply stage lost a request");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_free) |=> out_valid_q)
		else $error("output register lost a request");

endmodule

`default_nettype wire

>>> hdl/smaof_chan.sv
// one channel: sample history shift line and running window sum
// depends on smaof_pkg
`default_nettype none

module smaof_chan import smaof_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LENGTH)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire smaof_ctl_t              ctl,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	output logic signed [SUM_W-1:0]      sum
);

	logic signed [SAMPLE_W-1:0] hist_q [WINDOW_LENGTH];
	logic signed [SUM_W-1:0]    sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW_LENGTH; k++) begin
				hist_q[k] <= '0;
			end
			sum_q <= '0;
		end else if (ctl.push) begin
			for (int k = 0; k < WINDOW_LENGTH - 1; k++) begin
				hist_q[k] <= hist_q[k+1];
			end
			hist_q[WINDOW_LENGTH-1] <= sample;
			// oldest tap drops out, new sample comes in
			sum_q <= sum_q - SUM_W'(hist_q[0]) + SUM_W'(sample);
		end
	end

	assign sum = sum_q;

endmodule

`default_nettype wire

>>> hdl/smaof_div.sv
// divide a window sum by the window length, truncating toward zero
// reciprocal multiply stage; depends on smaof_pkg
`default_nettype none

module smaof_div import smaof_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LENGTH),
	localparam int SHIFT = SUM_W + $clog2(WINDOW_LENGTH),
	localparam int PROD_W = SUM_W + SHIFT + 1
) (
	input  wire logic                    clk,
	input  wire smaof_ctl_t              ctl,
	input  wire logic signed [SUM_W-1:0] sum,
	output logic signed [SAMPLE_W-1:0]   avg
);

	// ceil(2^SHIFT / N) is exact for every magnitude below 2^SHIFT / N
	localparam logic [SHIFT:0] RECIP = (SHIFT+1)'(
		((64'd1 << SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

	logic [SUM_W-1:0]    mag;
	logic [PROD_W-1:0]   prod_s2;
	logic                neg_s2;
	logic [SAMPLE_W-1:0] quo;

	assign mag = sum[SUM_W-1] ? unsigned'(-sum) : unsigned'(sum);

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			prod_s2 <= PROD_W'(mag) * PROD_W'(RECIP);
			neg_s2  <= sum[SUM_W-1];
		end
	end

	assign quo = prod_s2[SHIFT +: SAMPLE_W];
	assign avg = signed'(neg_s2 ? -quo : quo);

endmodule

`default_nettype wire
